// ----- design/fbwt_pkg.sv -----
// Shared types and constants of the flash block wear tracker.
package fbwt_pkg;

    localparam int OP_W     = 4;
    localparam int PLANE_W  = 3;
    localparam int BLOCK_W  = 10;
    localparam int ERASE_W  = 17;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_PROG_ISSUE = 4'd0;
    localparam logic [OP_W-1:0] OP_READ_ISSUE = 4'd1;
    localparam logic [OP_W-1:0] OP_PROG_DONE  = 4'd2;
    localparam logic [OP_W-1:0] OP_READ_DONE  = 4'd3;
    localparam logic [OP_W-1:0] OP_GC_START   = 4'd4;
    localparam logic [OP_W-1:0] OP_GC_END     = 4'd5;
    localparam logic [OP_W-1:0] OP_QUERY      = 4'd6;
    localparam logic [OP_W-1:0] OP_COLDEST    = 4'd7;
    localparam logic [OP_W-1:0] OP_SPREAD     = 4'd8;
    localparam logic [OP_W-1:0] OP_SET_ERASE  = 4'd9;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_SCAN_OUT
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
    } t_scan_ctl;

endpackage

// ----- design/fbwt_scan.sv -----
// Running minimum, maximum and coldest index over one plane scan.
module fbwt_scan #(
    parameter int IDX_W = 10
) (
    input  logic                         i_clk,
    input  fbwt_pkg::t_scan_ctl          i_ctl,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [fbwt_pkg::ERASE_W-1:0] i_erase,
    output logic [IDX_W-1:0]             o_cold,
    output logic [fbwt_pkg::ERASE_W-1:0] o_spread
);

    logic [fbwt_pkg::ERASE_W-1:0] r_lo;
    logic [fbwt_pkg::ERASE_W-1:0] r_hi;
    logic [IDX_W-1:0]             r_cold;

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            if (i_ctl.first) begin
                r_lo   <= i_erase;
                r_hi   <= i_erase;
                r_cold <= i_idx;
            end else begin
                if (i_erase < r_lo) begin
                    r_lo   <= i_erase;
                    r_cold <= i_idx;
                end
                if (i_erase > r_hi) begin
                    r_hi <= i_erase;
                end
            end
        end
    end

    assign o_cold   = r_cold;
    assign o_spread = r_hi - r_lo;

endmodule

// ----- design/flash_block_wear_tracker_core.sv -----
// Top level of the flash block wear tracker: entry memory, sequencer and output register.
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: opcode; tdata: plane, block, erase
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: status, coldest, spread, error
//
// Block opcodes read the entry from memory, then the update is written back.
// Coldest and spread scans read each block of the plane, one memory read a cycle.
// After reset a clearing pass writes PLANES * 2**clog2(BLOCKS_PER_PLANE) entries,
// one a cycle (8192 at the defaults), with s_axis_tready low.
// One item is worked at a time; a result waits in its final state while the
// output register is full.
module flash_block_wear_tracker_core #(
    parameter int PLANES           = 8,
    parameter int BLOCKS_PER_PLANE = 1024,
    parameter int COUNT_BITS       = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] plane_index, [12:3] block_index, [29:13] erase_value, [31:30] zero
    input  logic [fbwt_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [3:0] opcode
    input  logic [fbwt_pkg::S_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] gc_busy, [1] gc_allowed, [2] program_busy, [12:3] coldest_block,
    // [29:13] erase_spread, [30] count_error, [31] zero
    output logic [fbwt_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    localparam int PW    = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int BW    = $clog2(BLOCKS_PER_PLANE);
    localparam int AW    = PW + BW;
    localparam int DEPTH = PLANES * (2 ** BW);
    localparam int EW    = fbwt_pkg::ERASE_W;
    localparam int DW    = EW + 2 * COUNT_BITS + 1;
    localparam int P_LO  = EW;
    localparam int R_LO  = EW + COUNT_BITS;
    localparam int G_BIT = EW + 2 * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    fbwt_pkg::t_state r_state;
    fbwt_pkg::t_state n_state;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    logic [AW-1:0]                r_clr;
    logic [AW-1:0]                r_addr;
    logic [PW-1:0]                r_plane;
    logic [BW-1:0]                r_cnt;
    logic [fbwt_pkg::OP_W-1:0]    r_op;
    logic [EW-1:0]                r_eval;
    logic                         r_kill;
    logic                         r_scan_vld;
    logic [BW-1:0]                r_scan_idx;
    logic                         r_m_valid;
    logic [fbwt_pkg::M_DATA_W-1:0] r_m_data;

    logic                         acc;
    logic                         out_free;
    logic                         is_scan;
    logic                         in_kill;
    logic [PW+fbwt_pkg::PLANE_W-1:0] plane_ext;
    logic [BW+fbwt_pkg::BLOCK_W-1:0] block_ext;
    logic [PW-1:0]                in_plane;
    logic [BW-1:0]                in_block;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic                         load_out;
    logic [fbwt_pkg::M_DATA_W-1:0] out_data;

    logic [EW-1:0]         e_old;
    logic [COUNT_BITS-1:0] p_old;
    logic [COUNT_BITS-1:0] rd_old;
    logic                  g_old;
    logic [EW-1:0]         e_new;
    logic [COUNT_BITS-1:0] p_new;
    logic [COUNT_BITS-1:0] rd_new;
    logic                  g_new;
    logic                  err;

    fbwt_pkg::t_scan_ctl         scan_ctl;
    logic [BW-1:0]               scan_cold;
    logic [EW-1:0]               scan_spread;
    logic [BW+fbwt_pkg::BLOCK_W-1:0] cold_ext;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign is_scan  = (s_axis_tuser == fbwt_pkg::OP_COLDEST)
                   || (s_axis_tuser == fbwt_pkg::OP_SPREAD);

    assign plane_ext = {{PW{1'b0}}, s_axis_tdata[2:0]};
    assign block_ext = {{BW{1'b0}}, s_axis_tdata[12:3]};
    assign in_plane  = plane_ext[PW-1:0];
    assign in_block  = block_ext[BW-1:0];
    assign in_kill   = !(32'(s_axis_tdata[2:0]) < 32'(PLANES))
                    || (!is_scan && !(32'(s_axis_tdata[12:3]) < 32'(BLOCKS_PER_PLANE)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbwt_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = fbwt_pkg::ST_IDLE;
                end
            end
            fbwt_pkg::ST_IDLE: begin
                if (acc) begin
                    n_state = (is_scan && !in_kill) ? fbwt_pkg::ST_SCAN : fbwt_pkg::ST_UPDATE;
                end
            end
            fbwt_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = fbwt_pkg::ST_IDLE;
                end
            end
            fbwt_pkg::ST_SCAN: begin
                if (r_cnt == BW'(BLOCKS_PER_PLANE - 1)) begin
                    n_state = fbwt_pkg::ST_SCAN_LAST;
                end
            end
            fbwt_pkg::ST_SCAN_LAST: begin
                n_state = fbwt_pkg::ST_SCAN_OUT;
            end
            fbwt_pkg::ST_SCAN_OUT: begin
                if (out_free) begin
                    n_state = fbwt_pkg::ST_IDLE;
                end
            end
            default: n_state = fbwt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        e_old  = r_rdata[EW-1:0];
        p_old  = r_rdata[P_LO +: COUNT_BITS];
        rd_old = r_rdata[R_LO +: COUNT_BITS];
        g_old  = r_rdata[G_BIT];
        e_new  = e_old;
        p_new  = p_old;
        rd_new = rd_old;
        g_new  = g_old;
        err    = 1'b0;
        case (r_op)
            fbwt_pkg::OP_PROG_ISSUE: begin
                if (p_old == COUNT_MAX) err = 1'b1;
                else p_new = p_old + 1'b1;
            end
            fbwt_pkg::OP_READ_ISSUE: begin
                if (rd_old == COUNT_MAX) err = 1'b1;
                else rd_new = rd_old + 1'b1;
            end
            fbwt_pkg::OP_PROG_DONE: begin
                if (p_old == '0) err = 1'b1;
                else p_new = p_old - 1'b1;
            end
            fbwt_pkg::OP_READ_DONE: begin
                if (rd_old == '0) err = 1'b1;
                else rd_new = rd_old - 1'b1;
            end
            fbwt_pkg::OP_GC_START:  g_new = 1'b1;
            fbwt_pkg::OP_GC_END:    g_new = 1'b0;
            fbwt_pkg::OP_SET_ERASE: e_new = r_eval;
            default: ;
        endcase
    end

    assign cold_ext = {{fbwt_pkg::BLOCK_W{1'b0}}, scan_cold};

    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = {in_plane, in_block};
        wr_en         = 1'b0;
        wr_addr       = r_addr;
        wr_data       = {g_new, rd_new, p_new, e_new};
        load_out      = 1'b0;
        out_data      = '0;
        unique case (r_state)
            fbwt_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            fbwt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                rd_en         = acc && !in_kill && !is_scan;
            end
            fbwt_pkg::ST_UPDATE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    wr_en    = !r_kill;
                    if (!r_kill) begin
                        out_data[0]  = g_new;
                        out_data[1]  = (p_new == '0) && (rd_new == '0);
                        out_data[2]  = (p_new != '0);
                        out_data[30] = err;
                    end
                end
            end
            fbwt_pkg::ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = {r_plane, r_cnt};
            end
            fbwt_pkg::ST_SCAN_LAST: ;
            fbwt_pkg::ST_SCAN_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_op == fbwt_pkg::OP_COLDEST) begin
                        out_data[12:3] = cold_ext[fbwt_pkg::BLOCK_W-1:0];
                    end else begin
                        out_data[29:13] = scan_spread;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fbwt_pkg::ST_CLEAR;
            r_clr      <= '0;
            r_scan_vld <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_vld <= (r_state == fbwt_pkg::ST_SCAN);
            if (r_state == fbwt_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= r_cnt;
        if (acc) begin
            r_op    <= s_axis_tuser;
            r_eval  <= s_axis_tdata[29:13];
            r_kill  <= in_kill;
            r_plane <= in_plane;
            r_addr  <= {in_plane, in_block};
            r_cnt   <= '0;
        end else if (r_state == fbwt_pkg::ST_SCAN) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (load_out) begin
            r_m_data <= out_data;
        end
    end

    assign scan_ctl.vld   = r_scan_vld;
    assign scan_ctl.first = (r_scan_idx == '0);

    fbwt_scan #(
        .IDX_W (BW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_ctl    (scan_ctl),
        .i_idx    (r_scan_idx),
        .i_erase  (r_rdata[EW-1:0]),
        .o_cold   (scan_cold),
        .o_spread (scan_spread)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ----- sim/flash_block_wear_tracker_core_tb.sv -----
// Self-checking testbench of the flash block wear tracker core.
module flash_block_wear_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANES           = 8;
    localparam int BLOCKS_PER_PLANE = 1024;
    localparam int COUNT_BITS       = 8;
    localparam int ENTRIES          = PLANES * BLOCKS_PER_PLANE;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int HOLD_CYCLES      = 3000;
    localparam int PRINT_CAP        = 40;

    localparam logic [fbwt_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd10;
    localparam logic [fbwt_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [fbwt_pkg::OP_W-1:0]    op;
        logic [fbwt_pkg::PLANE_W-1:0] plane;
        logic [fbwt_pkg::BLOCK_W-1:0] block;
        logic [fbwt_pkg::ERASE_W-1:0] evalue;
    } t_wear_cmd;

    typedef struct packed {
        logic                         gc_busy;
        logic                         gc_allowed;
        logic                         prog_busy;
        logic [fbwt_pkg::BLOCK_W-1:0] coldest;
        logic [fbwt_pkg::ERASE_W-1:0] spread;
        logic                         cnt_err;
    } t_wear_rsp;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fbwt_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [fbwt_pkg::S_USER_W-1:0]   s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [fbwt_pkg::M_DATA_W-1:0]   m_axis_tdata;

    logic [fbwt_pkg::ERASE_W-1:0]    erase_tab [ENTRIES];
    logic [COUNT_BITS-1:0]           prog_tab  [ENTRIES];
    logic [COUNT_BITS-1:0]           read_tab  [ENTRIES];
    logic                            gc_tab    [ENTRIES];

    t_wear_cmd cmd_q[$];
    t_wear_rsp rsp_due_q[$];
    t_wear_cmd offered;

    int pushed_cnt   = 0;
    int accepted_cnt = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    bit hold_rx      = 1'b0;

    flash_block_wear_tracker_core #(
        .PLANES           (PLANES),
        .BLOCKS_PER_PLANE (BLOCKS_PER_PLANE),
        .COUNT_BITS       (COUNT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            erase_tab[i] = '0;
            prog_tab[i]  = '0;
            read_tab[i]  = '0;
            gc_tab[i]    = 1'b0;
        end
    end

    function automatic t_wear_rsp apply_wear_cmd(input t_wear_cmd c);
        t_wear_rsp r;
        int unsigned base;
        int unsigned idx;
        logic [fbwt_pkg::ERASE_W-1:0] lo;
        logic [fbwt_pkg::ERASE_W-1:0] hi;
        logic [fbwt_pkg::BLOCK_W-1:0] cold;
        r = '0;
        if (c.plane >= PLANES) return r;
        base = c.plane * BLOCKS_PER_PLANE;
        if (c.op == fbwt_pkg::OP_COLDEST || c.op == fbwt_pkg::OP_SPREAD) begin
            lo   = erase_tab[base];
            hi   = erase_tab[base];
            cold = '0;
            for (int i = 1; i < BLOCKS_PER_PLANE; i++) begin
                if (erase_tab[base + i] < lo) begin
                    lo   = erase_tab[base + i];
                    cold = i[fbwt_pkg::BLOCK_W-1:0];
                end
                if (erase_tab[base + i] > hi) hi = erase_tab[base + i];
            end
            if (c.op == fbwt_pkg::OP_COLDEST) r.coldest = cold;
            else r.spread = hi - lo;
            return r;
        end
        if (c.block >= BLOCKS_PER_PLANE) return r;
        idx = base + c.block;
        case (c.op)
            fbwt_pkg::OP_PROG_ISSUE: begin
                if (prog_tab[idx] == '1) r.cnt_err = 1'b1;
                else prog_tab[idx] = prog_tab[idx] + 1'b1;
            end
            fbwt_pkg::OP_READ_ISSUE: begin
                if (read_tab[idx] == '1) r.cnt_err = 1'b1;
                else read_tab[idx] = read_tab[idx] + 1'b1;
            end
            fbwt_pkg::OP_PROG_DONE: begin
                if (prog_tab[idx] == '0) r.cnt_err = 1'b1;
                else prog_tab[idx] = prog_tab[idx] - 1'b1;
            end
            fbwt_pkg::OP_READ_DONE: begin
                if (read_tab[idx] == '0) r.cnt_err = 1'b1;
                else read_tab[idx] = read_tab[idx] - 1'b1;
            end
            fbwt_pkg::OP_GC_START:  gc_tab[idx] = 1'b1;
            fbwt_pkg::OP_GC_END:    gc_tab[idx] = 1'b0;
            fbwt_pkg::OP_SET_ERASE: erase_tab[idx] = c.evalue;
            default: ;
        endcase
        r.gc_busy    = gc_tab[idx];
        r.gc_allowed = (prog_tab[idx] == '0) && (read_tab[idx] == '0);
        r.prog_busy  = (prog_tab[idx] != '0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < PRINT_CAP)
            $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // drive the input side
    always @(posedge i_clk) begin : drive
        int pick;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                rsp_due_q.push_back(apply_wear_cmd(offered));
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                pick = $urandom_range(0, 99);
                if (cmd_q.size() > 0 && pick >= idle_pct) begin
                    offered = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, offered.evalue, offered.block, offered.plane};
                    s_axis_tuser  <= offered.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // check the output side
    always @(posedge i_clk) begin : watch
        t_wear_rsp got;
        t_wear_rsp want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.gc_busy    = m_axis_tdata[0];
                got.gc_allowed = m_axis_tdata[1];
                got.prog_busy  = m_axis_tdata[2];
                got.coldest    = m_axis_tdata[12:3];
                got.spread     = m_axis_tdata[29:13];
                got.cnt_err    = m_axis_tdata[30];
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("unexpected item", int'(m_axis_tdata), 0);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (got.gc_busy != want.gc_busy)
                        report_mismatch("gc_busy", int'(got.gc_busy), int'(want.gc_busy));
                    if (got.gc_allowed != want.gc_allowed)
                        report_mismatch("gc_allowed", int'(got.gc_allowed),
                                        int'(want.gc_allowed));
                    if (got.prog_busy != want.prog_busy)
                        report_mismatch("program_busy", int'(got.prog_busy),
                                        int'(want.prog_busy));
                    if (got.coldest != want.coldest)
                        report_mismatch("coldest_block", int'(got.coldest), int'(want.coldest));
                    if (got.spread != want.spread)
                        report_mismatch("erase_spread", int'(got.spread), int'(want.spread));
                    if (got.cnt_err != want.cnt_err)
                        report_mismatch("count_error", int'(got.cnt_err), int'(want.cnt_err));
                end
            end
            m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("flash_block_wear_tracker_core_tb: errors");
            $finish;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (accepted_cnt >= 600);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    task automatic queue_cmd(input logic [fbwt_pkg::OP_W-1:0] op, input int plane,
                             input int block, input int evalue);
        t_wear_cmd c;
        c.op     = op;
        c.plane  = plane[fbwt_pkg::PLANE_W-1:0];
        c.block  = block[fbwt_pkg::BLOCK_W-1:0];
        c.evalue = evalue[fbwt_pkg::ERASE_W-1:0];
        cmd_q.push_back(c);
        pushed_cnt++;
    endtask

    task automatic queue_random_cmd();
        int r;
        logic [fbwt_pkg::OP_W-1:0] op;
        int blk;
        int ev;
        r = $urandom_range(0, 99);
        if (r < 18)      op = fbwt_pkg::OP_PROG_ISSUE;
        else if (r < 34) op = fbwt_pkg::OP_READ_ISSUE;
        else if (r < 46) op = fbwt_pkg::OP_PROG_DONE;
        else if (r < 58) op = fbwt_pkg::OP_READ_DONE;
        else if (r < 64) op = fbwt_pkg::OP_GC_START;
        else if (r < 70) op = fbwt_pkg::OP_GC_END;
        else if (r < 76) op = fbwt_pkg::OP_QUERY;
        else if (r < 79) op = fbwt_pkg::OP_COLDEST;
        else if (r < 82) op = fbwt_pkg::OP_SPREAD;
        else if (r < 94) op = fbwt_pkg::OP_SET_ERASE;
        else begin
            r  = $urandom_range(OP_UNUSED_LO, OP_UNUSED_HI);
            op = r[fbwt_pkg::OP_W-1:0];
        end
        r = $urandom_range(0, 9);
        if (r < 7) begin
            case ($urandom_range(0, 7))
                0: blk = 0;
                1: blk = 1;
                2: blk = 2;
                3: blk = 3;
                4: blk = 511;
                5: blk = 512;
                6: blk = BLOCKS_PER_PLANE - 2;
                default: blk = BLOCKS_PER_PLANE - 1;
            endcase
        end else begin
            blk = $urandom_range(0, BLOCKS_PER_PLANE - 1);
        end
        r = $urandom_range(0, 9);
        if (r < 3)       ev = $urandom_range(0, 3);
        else if (r == 3) ev = (1 << fbwt_pkg::ERASE_W) - 1;
        else             ev = $urandom_range(0, (1 << fbwt_pkg::ERASE_W) - 1);
        queue_cmd(op, $urandom_range(0, PLANES - 1), blk, ev);
    endtask

    task automatic wait_drained();
        wait (accepted_cnt == pushed_cnt && rsp_due_q.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(fbwt_pkg::OP_PROG_ISSUE, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_READ_ISSUE, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_QUERY, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_GC_START, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_GC_START, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_PROG_DONE, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_PROG_DONE, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_READ_DONE, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_READ_DONE, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_GC_END, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_GC_END, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_SET_ERASE, 7, BLOCKS_PER_PLANE - 1,
                  (1 << fbwt_pkg::ERASE_W) - 1);
        queue_cmd(fbwt_pkg::OP_SET_ERASE, 7, 0, 5);
        queue_cmd(fbwt_pkg::OP_SET_ERASE, 7, 1, 0);
        queue_cmd(fbwt_pkg::OP_COLDEST, 7, BLOCKS_PER_PLANE - 1,
                  (1 << fbwt_pkg::ERASE_W) - 1);
        queue_cmd(fbwt_pkg::OP_SPREAD, 7, 0, 0);
        queue_cmd(fbwt_pkg::OP_COLDEST, 0, 0, 0);
        queue_cmd(fbwt_pkg::OP_SPREAD, 0, 0, 0);
        queue_cmd(OP_UNUSED_LO, 3, 512, 0);
        queue_cmd(OP_UNUSED_HI, 3, 511, (1 << fbwt_pkg::ERASE_W) - 1);
        queue_cmd(fbwt_pkg::OP_QUERY, 7, BLOCKS_PER_PLANE - 1, 0);
        queue_cmd(fbwt_pkg::OP_SET_ERASE, 2, 341, 'h0AAAA);
        queue_cmd(fbwt_pkg::OP_SET_ERASE, 5, 682, 'h15555);

        // saturate both counters of one block
        for (int i = 0; i < (1 << COUNT_BITS) + 1; i++) begin
            queue_cmd(fbwt_pkg::OP_PROG_ISSUE, 6, 700, 0);
            queue_cmd(fbwt_pkg::OP_READ_ISSUE, 6, 700, 0);
        end
        queue_cmd(fbwt_pkg::OP_QUERY, 6, 700, 0);
        queue_cmd(fbwt_pkg::OP_PROG_DONE, 6, 700, 0);

        for (int i = 0; i < 200; i++) queue_random_cmd();
        wait_drained();

        idle_pct  = 74;
        stall_pct = 0;
        for (int i = 0; i < 240; i++) queue_random_cmd();
        wait_drained();

        idle_pct  = 0;
        stall_pct = 74;
        for (int i = 0; i < 240; i++) queue_random_cmd();
        wait_drained();

        idle_pct  = 29;
        stall_pct = 29;
        for (int i = 0; i < 240; i++) queue_random_cmd();
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("flash_block_wear_tracker_core_tb: clean");
        end else begin
            $display("flash_block_wear_tracker_core_tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/fbwt_pkg.sv
design/fbwt_scan.sv
design/flash_block_wear_tracker_core.sv
sim/flash_block_wear_tracker_core_tb.sv
